// ----- hw/rtl/bsmt_pkg.sv -----
// Backing-store map table: shared types and constants.
// No dependencies; imported by the top level and the checker.
package bsmt_pkg;

    localparam int NUM_STORES = 8;
    localparam int MAX_PAGES  = 256;
    localparam int PAGE_BYTES = 4096;

    localparam int IDX_W      = $clog2(NUM_STORES);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int VPN_W      = 32 - PAGE_SHIFT;
    // compare width: wide enough for page number and base + count
    localparam int CMP_W      = 33;

    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_MAP    = 2'd3
    } req_code_t;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  proc_id;
        logic [31:0] virtual_address;
        logic [19:0] base_page;
        logic [2:0]  store_sel;
        logic [8:0]  page_count;
    } bsmt_in_t;

    typedef struct packed {
        logic       status;
        logic [2:0] store_out;
        logic [7:0] page_offset;
    } bsmt_out_t;

    // one table entry as held in the entry RAM
    typedef struct packed {
        logic [5:0]  owner;
        logic [19:0] base;
        logic [8:0]  pages;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- hw/rtl/bsmt_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module bsmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/backing_store_map_table.sv -----
// Backing-store map table, top level. Uses bsmt_pkg and bsmt_ram.
// Allocate, free and map pass through S_EXEC and S_RESP after acceptance;
// lookup scans the entries in S_CHECK, one entry RAM read per cycle, then S_RESP.
// A new request is taken only in S_IDLE, so one request runs at a time.
// Reset (rst_n low, async): every entry unmapped, FSM idle, no response held.
// The response register lets the next request run while a result waits.
module backing_store_map_table (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  bsmt_pkg::bsmt_in_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output bsmt_pkg::bsmt_out_t rsp
);
    import bsmt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,   // waiting for a request; RAM reads entry 0 meanwhile
        S_EXEC,   // allocate, free or map
        S_CHECK,  // lookup: compare entry scan_reg, RAM fetches the next one
        S_RESP    // result waits for the response register
    } state_t;

    state_t                  state_reg, state_next;
    bsmt_in_t                req_reg;
    logic [IDX_W-1:0]        scan_reg, scan_next;
    logic [NUM_STORES-1:0]   mapped_reg, mapped_next;
    bsmt_out_t               res_reg, res_next;
    bsmt_out_t               rsp_reg, rsp_next;
    logic                    rsp_valid_reg, rsp_valid_next;

    // entry RAM ports
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    entry_t                  ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]      ram_rdata;
    entry_t                  ent;

    // request decode
    logic                    accept;
    logic [IDX_W-1:0]        sel_idx;
    logic                    sel_ok;
    logic                    count_ok;
    logic                    free_found;
    logic [IDX_W-1:0]        free_idx;

    // lookup datapath
    logic [VPN_W-1:0]        pgno;
    logic [CMP_W-1:0]        pg_ext, lo_ext, hi_ext, diff;
    logic                    owner_hit;
    logic                    in_range;

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Owner, base and page count live in RAM; the mapped flags live in
    // flops so reset clears them at once. An unmapped entry is never
    // used, so RAM contents need no reset.
    bsmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_STORES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ent = entry_t'(ram_rdata);

    assign sel_idx  = IDX_W'(req_reg.store_sel);
    assign sel_ok   = (32'(req_reg.store_sel) < NUM_STORES);
    assign count_ok = (req_reg.page_count != '0) && (32'(req_reg.page_count) <= MAX_PAGES);

    // Map writes the whole entry in the execute cycle. Lookup only reads,
    // and never overlaps a write since one request runs at a time.
    assign ram_we    = (state_reg == S_EXEC) && (req_reg.req_type == REQ_MAP)
                       && sel_ok && count_ok;
    assign ram_waddr = sel_idx;
    assign ram_wdata = '{owner: req_reg.proc_id,
                         base:  req_reg.base_page,
                         pages: req_reg.page_count};

    // Read pipelined one ahead: in idle entry 0 is fetched so the first
    // compare can start right after acceptance.
    assign ram_raddr = (state_reg == S_CHECK) ? scan_reg + 1'b1 : '0;

    // lowest unmapped entry
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_STORES - 1; i >= 0; i--)
        begin
            if (!mapped_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // page range test against the entry now on the RAM output
    assign pgno      = req_reg.virtual_address[31:PAGE_SHIFT];
    assign pg_ext    = CMP_W'(pgno);
    assign lo_ext    = CMP_W'(ent.base);
    assign hi_ext    = lo_ext + CMP_W'(ent.pages);
    assign diff      = pg_ext - lo_ext;
    assign owner_hit = mapped_reg[scan_reg] && (ent.owner == req_reg.proc_id);
    assign in_range  = (pg_ext >= lo_ext) && (pg_ext < hi_ext);

    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        mapped_next    = mapped_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                scan_next = '0;
                if (accept)
                begin
                    state_next = (req.req_type == REQ_LOOKUP) ? S_CHECK : S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_next   = '{status: STATUS_ERR, store_out: '0, page_offset: '0};
                state_next = S_RESP;
                unique case (req_reg.req_type)
                    REQ_ALLOC:
                    begin
                        if (free_found)
                        begin
                            res_next.status    = STATUS_OK;
                            res_next.store_out = 3'(free_idx);
                        end
                    end
                    REQ_FREE:
                    begin
                        if (sel_ok)
                        begin
                            mapped_next[sel_idx] = 1'b0;
                            res_next.status      = STATUS_OK;
                        end
                    end
                    REQ_MAP:
                    begin
                        if (sel_ok && count_ok)
                        begin
                            mapped_next[sel_idx] = 1'b1;
                            res_next.status      = STATUS_OK;
                        end
                    end
                    default:
                    begin
                        // lookup never comes here
                        res_next.status = STATUS_ERR;
                    end
                endcase
            end

            S_CHECK:
            begin
                res_next = '{status: STATUS_ERR, store_out: '0, page_offset: '0};
                if (owner_hit)
                begin
                    // first owner match decides; no further search
                    if (in_range)
                    begin
                        res_next.status      = STATUS_OK;
                        res_next.store_out   = 3'(scan_reg);
                        res_next.page_offset = diff[7:0];
                    end
                    state_next = S_RESP;
                end
                else if (32'(scan_reg) == NUM_STORES - 1)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            mapped_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            req_reg       <= '0;
            res_reg       <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            mapped_reg    <= mapped_next;
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                req_reg <= req;
            end
            res_reg       <= res_next;
            rsp_reg       <= rsp_next;
        end
    end

endmodule

// ----- hw/rtl/bsmt_checker.sv -----
// Port-level checks for backing_store_map_table, bound to the top level.
// Uses bsmt_pkg.
module bsmt_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input bsmt_pkg::bsmt_in_t  req,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input bsmt_pkg::bsmt_out_t rsp
);
    import bsmt_pkg::*;

    // one request in flight: ready drops right after a transaction
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // error responses carry no store or offset
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STATUS_ERR) |->
            (rsp.store_out == '0) && (rsp.page_offset == '0))
        else $error("error response with nonzero fields");

    // a new response only appears once a request has been in progress (req_ready low)
    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("response appeared without a request in progress");

endmodule

bind backing_store_map_table bsmt_checker u_bsmt_checker (.*);
